[src/hx711r_pkg.sv]
// ----------------------------------------------------------------------------
// hx711r_pkg
// Shared constants and types for the multi-channel load cell ADC reader.
// ----------------------------------------------------------------------------
package hx711r_pkg;
    localparam int CHANNELS    = 8;
    localparam int SAMPLE_BITS = 24;
    localparam int CH_W        = 3;
    localparam int VAL_W       = 25;
    localparam int SUM_W       = 32;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_ZERO = 2'd2;
    localparam logic [1:0] OP_LOAD = 2'd3;

    localparam logic [1:0] KIND_CLK  = 2'd0;
    localparam logic [1:0] KIND_MEAS = 2'd1;
    localparam logic [1:0] KIND_OFS  = 2'd2;
    localparam logic [1:0] KIND_BUSY = 2'd3;

    localparam logic [1:0] REG_GAIN  = 2'd0;
    localparam logic [1:0] REG_ZCNT  = 2'd1;
    localparam logic [1:0] REG_CHCNT = 2'd2;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_WAIT = 3'd1;
    localparam logic [2:0] PH_SHIFT = 3'd2;
    localparam logic [2:0] PH_GAIN = 3'd3;
    localparam logic [2:0] PH_DIV  = 3'd4;
    localparam logic [2:0] PH_EMIT = 3'd5;

    typedef struct packed {
        logic clear;      // clear shift word
        logic clear_all;  // clear word, offset and sum
        logic shift;      // shift in data bit
        logic accum;      // add word to sum
        logic load;       // load offset from bus
        logic div_start;  // start average division
    } lane_ctl_t;
endpackage

[src/hx711r_lane.sv]
// ----------------------------------------------------------------------------
// hx711r_lane
// One converter channel: shift word, offset, calibration sum, serial divider.
// ----------------------------------------------------------------------------
module hx711r_lane (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  hx711r_pkg::lane_ctl_t           ctl,
    input  logic                            data_bit,
    input  logic signed [hx711r_pkg::VAL_W-1:0] load_value,
    input  logic [8:0]                      divisor,
    output logic signed [hx711r_pkg::VAL_W-1:0] meas_value,
    output logic signed [hx711r_pkg::VAL_W-1:0] offset_value,
    output logic                            div_busy
);
    logic [23:0]                       word_reg;
    logic signed [hx711r_pkg::VAL_W-1:0] offset_reg;
    logic signed [hx711r_pkg::SUM_W-1:0] sum_reg;
    logic [hx711r_pkg::SUM_W-1:0]      quo_reg;
    logic [8:0]                        rem_reg;
    logic [5:0]                        cnt_reg;
    logic                              neg_reg;
    logic                              busy_reg;
    logic                              fin_reg;
    logic signed [25:0]                sat_sum;
    logic [9:0]                        trial;
    logic [hx711r_pkg::SUM_W-1:0]      mag;
    logic signed [hx711r_pkg::SUM_W-1:0] avg;

    assign sat_sum = 26'(signed'(word_reg)) + 26'(offset_reg);
    always_comb begin
        if (sat_sum > 26'sd16777215) begin
            meas_value = 25'sh0FFFFFF;
        end else if (sat_sum < -26'sd16777216) begin
            meas_value = 25'sh1000000;
        end else begin
            meas_value = sat_sum[24:0];
        end
    end
    assign mag   = sum_reg[31] ? 32'(-sum_reg) : sum_reg;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, divisor};
    // negated average, truncated toward zero
    assign avg   = neg_reg ? signed'(quo_reg) : -signed'(quo_reg);
    assign offset_value = offset_reg;
    assign div_busy     = busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg   <= '0;
            offset_reg <= '0;
            sum_reg    <= '0;
            busy_reg   <= 1'b0;
            fin_reg    <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (ctl.clear || ctl.clear_all) begin
                word_reg <= '0;
            end else if (ctl.shift) begin
                word_reg <= {word_reg[22:0], data_bit};
            end
            if (ctl.clear_all) begin
                offset_reg <= '0;
                sum_reg    <= '0;
            end else begin
                if (ctl.load) begin
                    offset_reg <= load_value;
                end else if (fin_reg) begin
                    offset_reg <= avg[24:0];
                end
                if (ctl.accum) begin
                    sum_reg <= sum_reg + 32'(signed'(word_reg));
                end
            end
            fin_reg <= busy_reg && !ctl.div_start && (cnt_reg == 6'd1);
            if (ctl.div_start) begin
                quo_reg  <= mag;
                rem_reg  <= '0;
                neg_reg  <= sum_reg[31];
                cnt_reg  <= 6'd32;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!trial[9]) begin
                    rem_reg <= trial[8:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[7:0], quo_reg[31]};
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end
endmodule

[src/multi_channel_hx711_reader_top.sv]
// ----------------------------------------------------------------------------
// multi_channel_hx711_reader_top
// Results: a tick's result is registered in the cycle after its transfer; a
// run end emits one result per active channel, one per cycle while results
// are taken; a calibration end runs a 32-step serial divide, then emits offsets.
// Throughput: one tick per cycle while results are taken; input stalls during
// result bursts and the divide. Reset: synchronous active-low aresetn; idle,
// offsets and sums cleared, registers to gain 128, zero count 1, 8 channels.
// ----------------------------------------------------------------------------
module multi_channel_hx711_reader_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [7:0]         s_data_lines,
    input  logic [2:0]         s_offset_channel,
    input  logic signed [24:0] s_offset_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_clock_level,
    output logic [1:0]         m_kind,
    output logic [2:0]         m_result_channel,
    output logic signed [24:0] m_value,
    output logic               m_last
);
    localparam int N = hx711r_pkg::CHANNELS;
    logic [1:0] gain_reg;
    logic [7:0] zcnt_reg;
    logic [3:0] chcnt_reg;
    logic [2:0] phase_reg;
    logic [4:0] pulse_reg;
    logic       clk_reg;
    logic       zero_reg;
    logic [7:0] zdone_reg;
    logic [2:0] emit_reg;
    logic [1:0] ekind_reg;
    logic [3:0] n_act;
    logic [7:0] mask;
    logic [1:0] extra;
    logic [7:0] zdone_inc;
    logic       wr;
    logic       acc;
    logic       div_go;
    logic       emit_fire;
    hx711r_pkg::lane_ctl_t ctl [N];
    logic signed [24:0] meas [N];
    logic signed [24:0] ofs [N];
    logic [N-1:0]       busy;
    logic [8:0]         divisor;
    logic [2:0]         addr_ch;
    // output register
    logic        ov_reg;
    logic        oc_reg;
    logic [1:0]  ok_reg;
    logic [2:0]  och_reg;
    logic [24:0] oval_reg;
    logic        ol_reg;
    logic        out_free;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= '0; zcnt_reg <= 8'd1; chcnt_reg <= 4'd8;
        end else if (wr) begin
            unique case (paddr[3:2])
                hx711r_pkg::REG_GAIN:  if (pwdata[1:0] != 2'd3) gain_reg <= pwdata[1:0];
                hx711r_pkg::REG_ZCNT:  zcnt_reg <= pwdata[7:0];
                hx711r_pkg::REG_CHCNT: chcnt_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr[3:2])
            hx711r_pkg::REG_GAIN:  prdata = {30'd0, gain_reg};
            hx711r_pkg::REG_ZCNT:  prdata = {24'd0, zcnt_reg};
            hx711r_pkg::REG_CHCNT: prdata = {28'd0, chcnt_reg};
            default:               prdata = '0;
        endcase
    end

    assign n_act = (chcnt_reg == 4'd0) ? 4'd1 : (chcnt_reg > 4'd8) ? 4'd8 : chcnt_reg;
    assign mask  = 8'((9'd1 << n_act) - 9'd1);
    assign extra = (gain_reg == 2'd1) ? 2'd3 : (gain_reg == 2'd2) ? 2'd2 : 2'd1;
    assign zdone_inc = zdone_reg + 8'd1;
    assign divisor = (zdone_reg == 8'd0) ? 9'd256 : {1'b0, zdone_reg};

    assign out_free = !ov_reg || m_ready;
    assign s_ready  = out_free && (phase_reg != hx711r_pkg::PH_DIV)
                      && (phase_reg != hx711r_pkg::PH_EMIT);
    assign acc = s_valid && s_ready;
    assign emit_fire = (phase_reg == hx711r_pkg::PH_EMIT) && out_free;
    assign addr_ch = s_offset_channel;

    logic gain_end;
    assign gain_end = acc && s_op == hx711r_pkg::OP_TICK && phase_reg == hx711r_pkg::PH_GAIN
                      && clk_reg && (pulse_reg + 5'd1 >= {3'd0, extra});
    assign div_go = gain_end && zero_reg && !(zdone_inc != 8'd0 && zdone_inc < zcnt_reg);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            ctl[i] = '0;
            if (acc && phase_reg == hx711r_pkg::PH_IDLE) begin
                ctl[i].clear     = (s_op == hx711r_pkg::OP_READ);
                ctl[i].clear_all = (s_op == hx711r_pkg::OP_ZERO) && zcnt_reg != 8'd0;
                ctl[i].load      = (s_op == hx711r_pkg::OP_LOAD) && addr_ch == 3'(i);
            end
            if (acc && s_op == hx711r_pkg::OP_TICK) begin
                if (phase_reg == hx711r_pkg::PH_WAIT && (s_data_lines & mask) == 8'd0)
                    ctl[i].clear = 1'b1;
                if (phase_reg == hx711r_pkg::PH_SHIFT && clk_reg)
                    ctl[i].shift = 1'b1;
                if (gain_end && zero_reg && 4'(i) < n_act)
                    ctl[i].accum = 1'b1;
            end
        end
    end

    logic [N-1:0] dstart_reg;
    // divide runs after sums settle: its start is registered, so it comes in the cycle after the accumulate
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_lane
            hx711r_pkg::lane_ctl_t c;
            always_comb begin
                c = ctl[g];
                c.div_start = dstart_reg[g];
            end
            hx711r_lane u_lane (
                .aclk(aclk), .aresetn(aresetn), .ctl(c),
                .data_bit(s_data_lines[g]), .load_value(s_offset_value),
                .divisor(divisor), .meas_value(meas[g]), .offset_value(ofs[g]),
                .div_busy(busy[g])
            );
        end
    endgenerate

    logic               div_wait_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dstart_reg <= '0;
            div_wait_reg <= 1'b0;
        end else begin
            dstart_reg <= div_go ? '1 : '0;
            div_wait_reg <= (dstart_reg != '0) ? 1'b1 : (busy == '0 ? 1'b0 : div_wait_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= hx711r_pkg::PH_IDLE; pulse_reg <= '0; clk_reg <= 1'b0;
            zero_reg <= 1'b0; zdone_reg <= '0; emit_reg <= '0; ekind_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            if (ov_reg && m_ready) ov_reg <= 1'b0;
            if (acc) begin
                ov_reg <= 1'b1; ok_reg <= hx711r_pkg::KIND_CLK; och_reg <= '0;
                oval_reg <= '0; ol_reg <= 1'b0; oc_reg <= clk_reg;
                if (phase_reg != hx711r_pkg::PH_IDLE && s_op != hx711r_pkg::OP_TICK) begin
                    ok_reg <= hx711r_pkg::KIND_BUSY;
                end else begin
                    unique case (phase_reg)
                        hx711r_pkg::PH_IDLE: begin
                            clk_reg <= 1'b0; oc_reg <= 1'b0;
                            if (s_op == hx711r_pkg::OP_READ) begin
                                zero_reg <= 1'b0; phase_reg <= hx711r_pkg::PH_WAIT;
                            end else if (s_op == hx711r_pkg::OP_ZERO && zcnt_reg != 8'd0) begin
                                zero_reg <= 1'b1; zdone_reg <= '0;
                                phase_reg <= hx711r_pkg::PH_WAIT;
                            end
                        end
                        hx711r_pkg::PH_WAIT: begin
                            if ((s_data_lines & mask) == 8'd0) begin
                                clk_reg <= 1'b1; oc_reg <= 1'b1; pulse_reg <= '0;
                                phase_reg <= hx711r_pkg::PH_SHIFT;
                            end
                        end
                        hx711r_pkg::PH_SHIFT: begin
                            clk_reg <= !clk_reg; oc_reg <= !clk_reg;
                            if (clk_reg) begin
                                if (pulse_reg == 5'(hx711r_pkg::SAMPLE_BITS - 1)) begin
                                    pulse_reg <= '0; phase_reg <= hx711r_pkg::PH_GAIN;
                                end else begin
                                    pulse_reg <= pulse_reg + 5'd1;
                                end
                            end
                        end
                        hx711r_pkg::PH_GAIN: begin
                            clk_reg <= !clk_reg; oc_reg <= !clk_reg;
                            if (clk_reg) begin
                                pulse_reg <= pulse_reg + 5'd1;
                                if (gain_end) begin
                                    pulse_reg <= '0;
                                    if (!zero_reg) begin
                                        ov_reg <= 1'b0; emit_reg <= '0;
                                        ekind_reg <= hx711r_pkg::KIND_MEAS;
                                        phase_reg <= hx711r_pkg::PH_EMIT;
                                    end else begin
                                        zdone_reg <= zdone_inc;
                                        if (div_go) begin
                                            ov_reg <= 1'b0;
                                            phase_reg <= hx711r_pkg::PH_DIV;
                                        end else begin
                                            phase_reg <= hx711r_pkg::PH_WAIT;
                                        end
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (phase_reg == hx711r_pkg::PH_DIV && dstart_reg == '0 && busy == '0
                && !div_wait_reg) begin
                emit_reg <= '0; ekind_reg <= hx711r_pkg::KIND_OFS;
                phase_reg <= hx711r_pkg::PH_EMIT;
            end
            if (emit_fire) begin
                ov_reg <= 1'b1; oc_reg <= 1'b0; ok_reg <= ekind_reg;
                och_reg <= emit_reg;
                oval_reg <= (ekind_reg == hx711r_pkg::KIND_MEAS) ? meas[emit_reg]
                                                                  : ofs[emit_reg];
                ol_reg <= (4'(emit_reg) + 4'd1 == n_act);
                emit_reg <= emit_reg + 3'd1;
                if (4'(emit_reg) + 4'd1 == n_act) begin
                    phase_reg <= hx711r_pkg::PH_IDLE; zero_reg <= 1'b0;
                end
            end
        end
    end

    assign m_valid          = ov_reg;
    assign m_clock_level    = oc_reg;
    assign m_kind           = ok_reg;
    assign m_result_channel = och_reg;
    assign m_value          = oval_reg;
    assign m_last           = ol_reg;
endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Random and directed test of the multi-channel load cell reader: a model of
// the serial read, calibration and offset logic predicts each result transfer.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic              clk_lvl;
        logic [1:0]        kind;
        logic [2:0]        chan;
        logic signed [24:0] val;
        logic              last;
    } reading_t;

    class reading_board;
        reading_t pending[$];
        int       errors;

        // model state
        logic [1:0]  gain;
        logic [7:0]  zcount;
        logic [3:0]  chcount;
        logic [2:0]  phase;
        int          pulses;
        logic        clk_hi;
        logic [23:0] words[8];
        int          offsets[8];
        longint      sums[8];
        logic [7:0]  zdone;
        logic        zeroing;

        function new();
            gain = 2'd0; zcount = 8'd1; chcount = 4'd8; phase = hx711r_pkg::PH_IDLE;
            pulses = 0; clk_hi = 1'b0; zdone = 8'd0; zeroing = 1'b0; errors = 0;
            for (int i = 0; i < 8; i++) begin
                words[i] = '0; offsets[i] = 0; sums[i] = 0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] v);
            if (idx == hx711r_pkg::REG_GAIN) begin
                if (v[1:0] <= 2'd2) gain = v[1:0];
            end else if (idx == hx711r_pkg::REG_ZCNT) begin
                zcount = v[7:0];
            end else if (idx == hx711r_pkg::REG_CHCNT) begin
                chcount = v[3:0];
            end
        endfunction

        function void add_expected(logic c, logic [1:0] k, int ch, int v, logic l);
            reading_t r;
            r.clk_lvl = c; r.kind = k; r.chan = ch[2:0]; r.val = v[24:0]; r.last = l;
            pending.insert(pending.size(), r);
        endfunction

        function void note_input(logic [1:0] op, logic [7:0] lines, logic [2:0] och,
                                 logic signed [24:0] oval);
            int     n, ext, v;
            int     div;
            longint avg;
            n = chcount < 4'd1 ? 1 : (chcount > 4'd8 ? 8 : int'(chcount));
            if (phase != hx711r_pkg::PH_IDLE && op != hx711r_pkg::OP_TICK) begin
                add_expected(clk_hi, hx711r_pkg::KIND_BUSY, 0, 0, 1'b0);
                return;
            end
            if (phase == hx711r_pkg::PH_IDLE) begin
                if (op == hx711r_pkg::OP_READ) begin
                    for (int i = 0; i < 8; i++) words[i] = '0;
                    zeroing = 1'b0; phase = hx711r_pkg::PH_WAIT;
                end else if (op == hx711r_pkg::OP_ZERO && zcount != 8'd0) begin
                    for (int i = 0; i < 8; i++) begin
                        words[i] = '0; offsets[i] = 0; sums[i] = 0;
                    end
                    zdone = 8'd0; zeroing = 1'b1; phase = hx711r_pkg::PH_WAIT;
                end else if (op == hx711r_pkg::OP_LOAD) begin
                    offsets[och] = int'(oval);
                end
                clk_hi = 1'b0;
                add_expected(1'b0, hx711r_pkg::KIND_CLK, 0, 0, 1'b0);
            end else if (phase == hx711r_pkg::PH_WAIT) begin
                if ((lines & ((9'd1 << n) - 1)) == 0) begin
                    for (int i = 0; i < 8; i++) words[i] = '0;
                    clk_hi = 1'b1; pulses = 0; phase = hx711r_pkg::PH_SHIFT;
                end
                add_expected(clk_hi, hx711r_pkg::KIND_CLK, 0, 0, 1'b0);
            end else if (phase == hx711r_pkg::PH_SHIFT) begin
                if (clk_hi) begin
                    clk_hi = 1'b0;
                    for (int i = 0; i < 8; i++) words[i] = {words[i][22:0], lines[i]};
                    pulses++;
                    if (pulses >= hx711r_pkg::SAMPLE_BITS) begin
                        pulses = 0; phase = hx711r_pkg::PH_GAIN;
                    end
                end else begin
                    clk_hi = 1'b1;
                end
                add_expected(clk_hi, hx711r_pkg::KIND_CLK, 0, 0, 1'b0);
            end else if (!clk_hi) begin
                clk_hi = 1'b1;
                add_expected(1'b1, hx711r_pkg::KIND_CLK, 0, 0, 1'b0);
            end else begin
                clk_hi = 1'b0;
                pulses++;
                if (pulses < (gain == 2'd1 ? 3 : (gain == 2'd2 ? 2 : 1))) begin
                    add_expected(1'b0, hx711r_pkg::KIND_CLK, 0, 0, 1'b0);
                    return;
                end
                pulses = 0;
                if (!zeroing) begin
                    for (int i = 0; i < n; i++) begin
                        ext = int'($signed(words[i]));
                        v = ext + offsets[i];
                        if (v > 16777215) v = 16777215;
                        if (v < -16777216) v = -16777216;
                        add_expected(1'b0, hx711r_pkg::KIND_MEAS, i, v, i + 1 == n);
                    end
                    phase = hx711r_pkg::PH_IDLE;
                    return;
                end
                for (int i = 0; i < n; i++) sums[i] += longint'($signed(words[i]));
                zdone = zdone + 8'd1;
                if (zdone != 8'd0 && zdone < zcount) begin
                    phase = hx711r_pkg::PH_WAIT;
                    add_expected(1'b0, hx711r_pkg::KIND_CLK, 0, 0, 1'b0);
                    return;
                end
                div = zdone != 8'd0 ? int'(zdone) : 256;
                for (int i = 0; i < n; i++) begin
                    avg = sums[i] / div;
                    offsets[i] = int'(-avg);
                    add_expected(1'b0, hx711r_pkg::KIND_OFS, i, offsets[i], i + 1 == n);
                end
                zeroing = 1'b0; phase = hx711r_pkg::PH_IDLE;
            end
        endfunction

        function void check(reading_t got);
            reading_t e;
            if (pending.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.clk_lvl !== e.clk_lvl) begin
                $error("clock_level exp %0d got %0d", e.clk_lvl, got.clk_lvl); errors++;
            end
            if (got.kind !== e.kind) begin
                $error("kind exp %0d got %0d", e.kind, got.kind); errors++;
            end
            if (got.chan !== e.chan) begin
                $error("result_channel exp %0d got %0d", e.chan, got.chan); errors++;
            end
            if (got.val !== e.val) begin
                $error("value exp %0d got %0d", e.val, got.val); errors++;
            end
            if (got.last !== e.last) begin
                $error("last exp %0d got %0d", e.last, got.last); errors++;
            end
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [3:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 0;
    logic               s_ready;
    logic [1:0]         s_op = hx711r_pkg::OP_TICK;
    logic [7:0]         s_data_lines = 0;
    logic [2:0]         s_offset_channel = 0;
    logic signed [24:0] s_offset_value = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic               m_clock_level;
    logic [1:0]         m_kind;
    logic [2:0]         m_result_channel;
    logic signed [24:0] m_value;
    logic               m_last;

    multi_channel_hx711_reader_top dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    reading_board board = new();
    int  send_idle_pct, recv_stall_pct;
    int  items_sent, results_seen, quiet_cycles;

    // result side: stall policy and checking
    always @(posedge aclk) begin
        reading_t r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                r.clk_lvl = m_clock_level; r.kind = m_kind; r.chan = m_result_channel;
                r.val = m_value; r.last = m_last;
                board.check(r);
                results_seen++;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles > 5000) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.write_reg(idx, v);
    endtask

    // valid stays up between back-to-back transfers; it drops only when idling or draining
    task automatic send(logic [1:0] op, logic [7:0] lines, logic [2:0] och,
                        logic signed [24:0] oval);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1; s_op <= op; s_data_lines <= lines;
        s_offset_channel <= och; s_offset_value <= oval;
        do @(posedge aclk); while (!s_ready);
        board.note_input(op, lines, och, oval);
        items_sent++;
    endtask

    task automatic drain();
        int guard;
        s_valid <= 0;
        guard = 0;
        while (board.pending.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (60) @(posedge aclk);
    endtask

    // one read or calibration run: wait, 24 bits, gain pulses, with random lines; noisy adds a stray command
    task automatic full_read(logic [1:0] op, bit noisy);
        send(op, 8'h00, 3'd0, 25'sd0);
        if ($urandom_range(3) == 0) send(hx711r_pkg::OP_TICK, 8'hff, 3'd0, 25'sd0);
        if (noisy) send(logic'($urandom_range(1)) ? hx711r_pkg::OP_READ : hx711r_pkg::OP_LOAD,
                        8'h00, 3'd0, 25'sd0);
        while (board.phase != hx711r_pkg::PH_IDLE) begin
            logic [7:0] ln;
            ln = 8'($urandom);
            if (board.phase == hx711r_pkg::PH_WAIT) ln = (board.chcount == 4'd0) ? 8'h00 :
                                             ($urandom_range(3) == 0 ? ln : 8'h00);
            send(hx711r_pkg::OP_TICK, ln, 3'd0, 25'sd0);
        end
    endtask

    task automatic set_idle(int si, int rs);
        send_idle_pct = si; recv_stall_pct = rs;
    endtask

    initial begin
        set_idle(0, 0);
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: offsets of +/-2^23 and -1, then reads and a calibration
        send(hx711r_pkg::OP_LOAD, 8'h00, 3'd0, 25'sd8388608);
        send(hx711r_pkg::OP_LOAD, 8'h00, 3'd7, -25'sd8388608);
        send(hx711r_pkg::OP_LOAD, 8'hff, 3'd3, 25'h1ffffff);
        send(hx711r_pkg::OP_TICK, 8'hff, 3'd0, 25'sd0);
        full_read(hx711r_pkg::OP_READ, 1'b1);
        drain();
        write_reg(hx711r_pkg::REG_GAIN, 32'd1);
        write_reg(hx711r_pkg::REG_ZCNT, 32'd0);
        write_reg(hx711r_pkg::REG_CHCNT, 32'd0);
        send(hx711r_pkg::OP_ZERO, 8'h00, 3'd0, 25'sd0);
        full_read(hx711r_pkg::OP_READ, 1'b0);
        drain();
        write_reg(hx711r_pkg::REG_GAIN, 32'd3);
        write_reg(hx711r_pkg::REG_ZCNT, 32'd2);
        write_reg(hx711r_pkg::REG_CHCNT, 32'd15);
        full_read(hx711r_pkg::OP_ZERO, 1'b1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            int sel;
            case (ph)
                0: set_idle(0, 0);
                1: set_idle(62, 0);
                2: set_idle(0, 62);
                default: set_idle(28, 28);
            endcase
            drain();
            write_reg(hx711r_pkg::REG_GAIN, 32'($urandom_range(3)));
            write_reg(hx711r_pkg::REG_ZCNT, ph == 3 ? 32'd255 : 32'($urandom_range(1, 2)));
            write_reg(hx711r_pkg::REG_CHCNT, ph == 0 ? 32'd1 : 32'($urandom_range(0, 15)));
            sel = $urandom_range(9);
            if (sel < 6) full_read(hx711r_pkg::OP_READ, 1'b0);
            else if (sel < 7 && ph != 3) full_read(hx711r_pkg::OP_ZERO, 1'b0);
            else if (sel < 8) full_read(hx711r_pkg::OP_READ, 1'b1);
            else send(logic'($urandom_range(1)) ? hx711r_pkg::OP_LOAD : hx711r_pkg::OP_TICK,
                      8'($urandom), 3'($urandom), 25'($urandom));
            drain();
        end
        if (items_sent < 410) begin
            set_idle(0, 0);
            write_reg(hx711r_pkg::REG_ZCNT, 32'd1);
            write_reg(hx711r_pkg::REG_CHCNT, 32'd8);
            while (items_sent < 410) full_read(hx711r_pkg::OP_READ, 1'b0);
        end
        drain();
        $display("Covered %0d input transfers and %0d result transfers across four", items_sent,
                 results_seen);
        $display("idle mixes, all registers, reads, calibrations and offset loads.");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
